### rtl/periodic_task_release_bank_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task release bank
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_RELEASE_BANK_CORE_MACROS_SVH
`define PERIODIC_TASK_RELEASE_BANK_CORE_MACROS_SVH

// Assertion that is switched off while reset is held
`define PTRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also looks at reset itself
`define PTRB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ptrb_pkg.sv
// ----------------------------------------------------------------------------
// ptrb_pkg
// Types, constants and codes shared by the periodic task release bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptrb_pkg;

  // Bank size and derived widths
  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // Request mode codes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_CREATE  = 3'd1;
  localparam logic [2:0] MODE_SUSPEND = 3'd2;
  localparam logic [2:0] MODE_RESUME  = 3'd3;
  localparam logic [2:0] MODE_DELETE  = 3'd4;

  // Classified operations handed to the back end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_CREATE,
    OP_REJECT,
    OP_SUSPEND,
    OP_RESUME,
    OP_DELETE
  } op_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    EX_IDLE,
    EX_SCAN,
    EX_DRAIN
  } ex_state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  slot;
    logic [15:0] period;
    logic [15:0] start_delay;
    logic        handler_given;
  } in_req_t;

  typedef struct packed {
    logic [7:0] fire_mask;
    logic       status;
  } out_res_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [15:0]      period;
    logic [15:0]      delay;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/ptrb_front.sv
// ----------------------------------------------------------------------------
// ptrb_front
// Classifies an incoming request into a back end command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptrb_front (
  input  ptrb_pkg::in_req_t req,
  output ptrb_pkg::cmd_t    cmd
);

  logic in_range;

  assign in_range = int'(req.slot) < ptrb_pkg::NUM_SLOTS;

  // Out-of-range slot operations do nothing; a create without a handler
  // is rejected whatever the slot.
  always_comb begin
    cmd.idx    = ptrb_pkg::IDX_W'(req.slot);
    cmd.period = req.period;
    cmd.delay  = req.start_delay;
    cmd.op     = ptrb_pkg::OP_NOP;
    unique case (req.mode)
      ptrb_pkg::MODE_TICK: begin
        cmd.op = ptrb_pkg::OP_TICK;
      end
      ptrb_pkg::MODE_CREATE: begin
        if (!req.handler_given) begin
          cmd.op = ptrb_pkg::OP_REJECT;
        end else if (in_range) begin
          cmd.op = ptrb_pkg::OP_CREATE;
        end
      end
      ptrb_pkg::MODE_SUSPEND: begin
        if (in_range) cmd.op = ptrb_pkg::OP_SUSPEND;
      end
      ptrb_pkg::MODE_RESUME: begin
        if (in_range) cmd.op = ptrb_pkg::OP_RESUME;
      end
      ptrb_pkg::MODE_DELETE: begin
        if (in_range) cmd.op = ptrb_pkg::OP_DELETE;
      end
      default: begin
        cmd.op = ptrb_pkg::OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/ptrb_cmd_queue.sv
// ----------------------------------------------------------------------------
// ptrb_cmd_queue
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptrb_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  ptrb_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output logic           not_empty,
  output ptrb_pkg::cmd_t rd_cmd
);

  ptrb_pkg::cmd_t                  mem_r [ptrb_pkg::CQ_DEPTH];
  logic [ptrb_pkg::CQ_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ptrb_pkg::CQ_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ptrb_pkg::CQ_CW-1:0]      count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full      = count_r == ptrb_pkg::CQ_CW'(ptrb_pkg::CQ_DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_cmd    = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ptrb_pkg::CQ_AW'(ptrb_pkg::CQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + ptrb_pkg::CQ_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ptrb_pkg::CQ_AW'(ptrb_pkg::CQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + ptrb_pkg::CQ_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + ptrb_pkg::CQ_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - ptrb_pkg::CQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/ptrb_exec.sv
// ----------------------------------------------------------------------------
// ptrb_exec
// Back end: holds the slot bank, scans it one slot per cycle on a tick,
// and applies create, suspend, resume and delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptrb_exec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cq_valid,
  input  ptrb_pkg::cmd_t     cq_cmd,
  output logic               cq_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output ptrb_pkg::out_res_t out_res
);

  localparam int N  = ptrb_pkg::NUM_SLOTS;
  localparam int IW = ptrb_pkg::IDX_W;

  // Period and countdown memories; valid bits stand in for reset to zero
  logic [15:0] period_mem [N];
  logic [15:0] count_mem  [N];

  ptrb_pkg::ex_state_t state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  logic [IW-1:0]       s1_idx_r, s1_idx_nxt;
  logic [7:0]          mask_r, mask_nxt;
  logic                out_valid_r, out_valid_nxt;
  ptrb_pkg::out_res_t  out_res_r, out_res_nxt;
  logic [N-1:0]        taken_r, taken_nxt;
  logic [N-1:0]        paused_r, paused_nxt;
  logic [N-1:0]        pv_r, pv_nxt;
  logic [N-1:0]        cv_r, cv_nxt;
  logic [15:0]         cd_q_r, pd_q_r;

  logic                out_free;
  logic [15:0]         cd_cur, pd_cur, cd_new;
  logic                cd_zero, s1_live, s1_fire;
  logic [7:0]          mask_upd;
  logic                rd_en, pwr_en, cwr_en;
  logic [IW-1:0]       cwr_addr;
  logic [15:0]         cwr_data;

  assign out_empty = !out_valid_r;
  assign out_res   = out_res_r;
  assign out_free  = !out_valid_r || out_pop;

  // Scan stage: update of the slot whose entries were read last cycle
  always_comb begin
    cd_cur   = cv_r[s1_idx_r] ? cd_q_r : 16'd0;
    pd_cur   = pv_r[s1_idx_r] ? pd_q_r : 16'd0;
    cd_zero  = cd_cur == 16'd0;
    s1_live  = s1_valid_r && !paused_r[s1_idx_r];
    cd_new   = cd_zero ? (pd_cur - 16'd1) : (cd_cur - 16'd1);
    s1_fire  = s1_live && cd_zero && taken_r[s1_idx_r];
    // slots at index 8 and above shift out of the mask
    mask_upd = mask_r | (s1_fire ? (8'd1 << s1_idx_r) : 8'd0);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    s1_valid_nxt  = 1'b0;
    s1_idx_nxt    = idx_r;
    mask_nxt      = mask_r;
    taken_nxt     = taken_r;
    paused_nxt    = paused_r;
    pv_nxt        = pv_r;
    cv_nxt        = cv_r;
    rd_en         = 1'b0;
    pwr_en        = 1'b0;
    cwr_en        = 1'b0;
    cwr_addr      = cq_cmd.idx;
    cwr_data      = cq_cmd.delay;
    cq_pop        = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    out_res_nxt   = out_res_r;

    if (s1_live) begin
      cwr_en           = 1'b1;
      cwr_addr         = s1_idx_r;
      cwr_data         = cd_new;
      cv_nxt[s1_idx_r] = 1'b1;
    end
    if (s1_valid_r) begin
      mask_nxt = mask_upd;
    end

    unique case (state_r)
      ptrb_pkg::EX_IDLE: begin
        if (cq_valid && out_free) begin
          cq_pop                = 1'b1;
          out_valid_nxt         = 1'b1;
          out_res_nxt.fire_mask = 8'd0;
          out_res_nxt.status    = cq_cmd.op == ptrb_pkg::OP_REJECT;
          unique case (cq_cmd.op)
            ptrb_pkg::OP_TICK: begin
              out_valid_nxt = 1'b0;
              state_nxt     = ptrb_pkg::EX_SCAN;
              idx_nxt       = '0;
              mask_nxt      = 8'd0;
            end
            ptrb_pkg::OP_CREATE: begin
              if (!taken_r[cq_cmd.idx]) begin
                pwr_en                 = 1'b1;
                cwr_en                 = 1'b1;
                pv_nxt[cq_cmd.idx]     = 1'b1;
                cv_nxt[cq_cmd.idx]     = 1'b1;
                taken_nxt[cq_cmd.idx]  = 1'b1;
                paused_nxt[cq_cmd.idx] = 1'b0;
              end
            end
            ptrb_pkg::OP_SUSPEND: paused_nxt[cq_cmd.idx] = 1'b1;
            ptrb_pkg::OP_RESUME:  paused_nxt[cq_cmd.idx] = 1'b0;
            ptrb_pkg::OP_DELETE:  taken_nxt[cq_cmd.idx]  = 1'b0;
            default: begin
              // no-op and rejected create leave the bank alone
            end
          endcase
        end
      end
      ptrb_pkg::EX_SCAN: begin
        rd_en        = 1'b1;
        s1_valid_nxt = 1'b1;
        s1_idx_nxt   = idx_r;
        if (idx_r == IW'(N - 1)) begin
          state_nxt = ptrb_pkg::EX_DRAIN;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ptrb_pkg::EX_DRAIN: begin
        // last slot is in the scan stage; publish the mask
        out_valid_nxt         = 1'b1;
        out_res_nxt.fire_mask = mask_upd;
        out_res_nxt.status    = 1'b0;
        state_nxt             = ptrb_pkg::EX_IDLE;
      end
      default: begin
        state_nxt = ptrb_pkg::EX_IDLE;
      end
    endcase
  end

  // Control and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptrb_pkg::EX_IDLE;
      idx_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      taken_r     <= '0;
      paused_r    <= '0;
      pv_r        <= '0;
      cv_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      taken_r     <= taken_nxt;
      paused_r    <= paused_nxt;
      pv_r        <= pv_nxt;
      cv_r        <= cv_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_idx_r  <= s1_idx_nxt;
    mask_r    <= mask_nxt;
    out_res_r <= out_res_nxt;
  end

  // Slot memories: one write port each, registered read at the scan index
  always_ff @(posedge clk) begin
    if (pwr_en) begin
      period_mem[cq_cmd.idx] <= cq_cmd.period;
    end
    if (cwr_en) begin
      count_mem[cwr_addr] <= cwr_data;
    end
    if (rd_en) begin
      cd_q_r <= count_mem[idx_r];
      pd_q_r <= period_mem[idx_r];
    end
  end

endmodule

`default_nettype wire

### rtl/periodic_task_release_bank_core.sv
// Tick: after command pickup the scan visits one slot per cycle through the
//   slot memories, then the drain state publishes the release mask.
// Create, suspend, resume, delete: result registered at pickup.
// Throughput: one request at a time; others 1 per cycle while results are popped.
// Synchronous active-low reset empties both queues and frees, unpauses and
//   zeroes every slot at once (valid bits, no clearing pass).
// ----------------------------------------------------------------------------
// periodic_task_release_bank_core
// Bank of periodic task slots with tick scan and slot management requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_release_bank_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ptrb_pkg::in_req_t  in_req,
  output logic               out_empty,
  input  logic               out_pop,
  output ptrb_pkg::out_res_t out_res
);

  ptrb_pkg::cmd_t front_cmd;
  ptrb_pkg::cmd_t head_cmd;
  logic           head_valid;
  logic           head_pop;

  ptrb_front u_front (
    .req (in_req),
    .cmd (front_cmd)
  );

  ptrb_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .wr_cmd    (front_cmd),
    .pop       (head_pop),
    .not_empty (head_valid),
    .rd_cmd    (head_cmd)
  );

  ptrb_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_valid  (head_valid),
    .cq_cmd    (head_cmd),
    .cq_pop    (head_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

### rtl/ptrb_checker.sv
// ----------------------------------------------------------------------------
// ptrb_checker
// Port-level checks of the task release bank, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_task_release_bank_core_macros.svh"

module ptrb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input ptrb_pkg::out_res_t out_res
);

  // Reset leaves no result waiting and room for requests
  `PTRB_ASSERT_RST(a_rst_empty, !rst_n |=> out_empty, "result present after reset")
  `PTRB_ASSERT_RST(a_rst_room, !rst_n |=> !in_full, "queue full after reset")

  // A result never carries releases and a rejection together
  `PTRB_ASSERT(a_excl, !out_empty |-> !(out_res.status && |out_res.fire_mask), "mask and reject")

  // A waiting result holds until taken
  `PTRB_ASSERT(a_hold, !out_empty && !out_pop |=> !out_empty && $stable(out_res), "not held")

endmodule

bind periodic_task_release_bank_core ptrb_checker u_ptrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_res   (out_res)
);

`default_nettype wire

### verif/tb_periodic_task_release_bank_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_release_bank_core
// Self-checking bench for the task release bank. A directed sequence covers
// zero and full-scale periods, rejected and repeated creates, pause, resume,
// delete on taken slots and unused mode codes. Random traffic then
// keeps slots cycling through create, tick, pause and delete. Every accepted
// request is run through a cycle-free model of the slot bank, and each popped
// result is compared with the oldest prediction. Both queue sides idle at
// random.
// ----------------------------------------------------------------------------

module tb_periodic_task_release_bank_core;
  import ptrb_pkg::*;

  // Slot bank model plus queue of predicted results
  class release_tracker;
    logic [15:0] period_q[NUM_SLOTS];
    logic [15:0] countdown_q[NUM_SLOTS];
    logic        taken_q[NUM_SLOTS];
    logic        paused_q[NUM_SLOTS];
    out_res_t    expected_results[$];
    int          n_errors;
    int          n_requests;
    int          n_ticks;
    int          n_releases;
    int          n_rejects;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        period_q[i]    = '0;
        countdown_q[i] = '0;
        taken_q[i]     = 1'b0;
        paused_q[i]    = 1'b0;
      end
      n_errors   = 0;
      n_requests = 0;
      n_ticks    = 0;
      n_releases = 0;
      n_rejects  = 0;
    endfunction

    function void report_error(string msg);
      n_errors++;
      if (n_errors <= 10) $display("tb: ERROR at %0t: %s", $realtime, msg);
    endfunction

    // One tick: every running slot counts down or reloads
    function logic [7:0] advance_tick();
      logic [7:0] mask;
      mask = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!paused_q[i]) begin
          if (countdown_q[i] == 16'd0) begin
            if (taken_q[i] && i < 8) mask[i] = 1'b1;
            countdown_q[i] = period_q[i] - 16'd1;
          end else begin
            countdown_q[i] = countdown_q[i] - 16'd1;
          end
        end
      end
      return mask;
    endfunction

    // Accepted request: update the model and queue its result
    function void note_request(in_req_t r);
      out_res_t res;
      logic     in_range;
      res      = '0;
      in_range = int'(r.slot) < NUM_SLOTS;
      n_requests++;
      case (r.mode)
        MODE_TICK: begin
          res.fire_mask = advance_tick();
          n_ticks++;
          n_releases += $countones(res.fire_mask);
        end
        MODE_CREATE: begin
          if (!r.handler_given) begin
            res.status = 1'b1;
            n_rejects++;
          end else if (in_range && !taken_q[r.slot]) begin
            period_q[r.slot]    = r.period;
            countdown_q[r.slot] = r.start_delay;
            taken_q[r.slot]     = 1'b1;
            paused_q[r.slot]    = 1'b0;
          end
        end
        MODE_SUSPEND: if (in_range) paused_q[r.slot] = 1'b1;
        MODE_RESUME:  if (in_range) paused_q[r.slot] = 1'b0;
        MODE_DELETE:  if (in_range) taken_q[r.slot] = 1'b0;
        default: ;
      endcase
      expected_results.push_back(res);
    endfunction

    // Popped result against the oldest prediction
    function void check_result(out_res_t got);
      out_res_t want;
      if (expected_results.size() == 0) begin
        report_error($sformatf("unexpected result mask=%02h status=%0b",
                               got.fire_mask, got.status));
        return;
      end
      want = expected_results.pop_front();
      if (got.fire_mask !== want.fire_mask)
        report_error($sformatf("fire_mask expected %02h got %02h",
                               want.fire_mask, got.fire_mask));
      if (got.status !== want.status)
        report_error($sformatf("status expected %0b got %0b",
                               want.status, got.status));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  typedef enum logic [1:0] {
    POP_STEADY,
    POP_COIN,
    POP_EVERY4,
    POP_SPARSE
  } pop_style_t;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  in_req_t  in_req  = '0;
  logic     out_empty;
  logic     out_pop = 1'b0;
  out_res_t out_res;

  release_tracker tracker = new();

  pop_style_t pop_style = POP_STEADY;
  int         pop_left  = 100;
  int         pop_phase = 0;

  periodic_task_release_bank_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Request and result monitors
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) tracker.note_request(in_req);
    if (rst_n && out_pop && !out_empty) tracker.check_result(out_res);
  end

  // Receiver stalls: the pop style is picked anew at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (pop_left == 0) begin
        pop_style = pop_style_t'($urandom_range(0, 3));
        pop_left  = $urandom_range(64, 256);
      end else begin
        pop_left--;
      end
      pop_phase++;
      case (pop_style)
        POP_STEADY: out_pop <= 1'b1;
        POP_COIN:   out_pop <= $urandom_range(0, 1);
        POP_EVERY4: out_pop <= (pop_phase % 4 == 0);
        default:    out_pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic in_req_t make_req(logic [2:0] mode, logic [2:0] slot,
                                       logic [15:0] period, logic [15:0] delay,
                                       logic handler);
    in_req_t r;
    r.mode          = mode;
    r.slot          = slot;
    r.period        = period;
    r.start_delay   = delay;
    r.handler_given = handler;
    return r;
  endfunction

  // Mostly ticks and short-period creates so slots keep releasing
  function automatic in_req_t random_req();
    in_req_t r;
    int      pick;
    r.slot          = $urandom_range(0, 7);
    r.handler_given = ($urandom_range(0, 9) != 0);
    r.period        = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    r.start_delay   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
    pick = $urandom_range(0, 99);
    if (pick < 55)      r.mode = MODE_TICK;
    else if (pick < 72) r.mode = MODE_CREATE;
    else if (pick < 80) r.mode = MODE_SUSPEND;
    else if (pick < 88) r.mode = MODE_RESUME;
    else if (pick < 95) r.mode = MODE_DELETE;
    else                r.mode = MODE_DELETE + 3'($urandom_range(1, 3));
    return r;
  endfunction

  // Hold the request until the queue takes it; push stays high on return
  task automatic send_req(in_req_t r);
    in_push <= 1'b1;
    in_req  <= r;
    do @(posedge clk); while (in_full);
  endtask

  initial begin
    in_req_t stim[$];
    int      burst;
    int      guard;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    stim.push_back(make_req(MODE_TICK,    3'd0, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_CREATE,  3'd0, 16'd0,     16'd0,     1'b1));
    stim.push_back(make_req(MODE_TICK,    3'd0, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_CREATE,  3'd0, 16'd5,     16'd3,     1'b1));
    stim.push_back(make_req(MODE_CREATE,  3'd1, 16'd4,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_CREATE,  3'd7, 16'hFFFF,  16'hFFFF,  1'b1));
    stim.push_back(make_req(MODE_CREATE,  3'd2, 16'd1,     16'd1,     1'b1));
    stim.push_back(make_req(MODE_TICK,    3'd7, 16'hFFFF,  16'hFFFF,  1'b1));
    stim.push_back(make_req(MODE_TICK,    3'd0, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_SUSPEND, 3'd2, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_TICK,    3'd0, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_RESUME,  3'd2, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_TICK,    3'd0, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_SUSPEND, 3'd5, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_RESUME,  3'd5, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_DELETE,  3'd2, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_TICK,    3'd0, 16'd0,     16'd0,     1'b0));
    // create on a paused free slot must start it running
    stim.push_back(make_req(MODE_SUSPEND, 3'd3, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_CREATE,  3'd3, 16'd2,     16'd0,     1'b1));
    stim.push_back(make_req(MODE_TICK,    3'd0, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_DELETE + 3'd1, 3'd4, 16'd9, 16'd9,   1'b1));
    stim.push_back(make_req(MODE_DELETE + 3'd3, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1));
    stim.push_back(make_req(MODE_DELETE,  3'd0, 16'd0,     16'd0,     1'b0));
    stim.push_back(make_req(MODE_CREATE,  3'd0, 16'hFFFF,  16'hFFFF,  1'b0));
    stim.push_back(make_req(MODE_TICK,    3'd0, 16'd0,     16'd0,     1'b0));

    // Random part fills the run up to its total
    while (stim.size() < 1650) begin
      stim.push_back(random_req());
    end

    // Bursty sender
    while (stim.size() != 0) begin
      burst = $urandom_range(1, 16);
      while (burst != 0 && stim.size() != 0) begin
        send_req(stim.pop_front());
        burst--;
      end
      if (stim.size() != 0 && $urandom_range(0, 3) != 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_push <= 1'b0;

    // Drain, then allow a full tick scan for stray results
    guard = 0;
    while (tracker.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (NUM_SLOTS + 12) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report_error($sformatf("%0d results never arrived", tracker.pending()));

    $display("tb: %0d requests checked, %0d ticks, %0d releases, %0d rejected creates",
             tracker.n_requests, tracker.n_ticks, tracker.n_releases, tracker.n_rejects);
    $display("tb: %0d mismatches", tracker.n_errors);
    if (tracker.n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
